// ===== sv/keyed_record_table_with_mean_macros.svh =====
// Assertion macros for the keyed record table.
// Included by files that carry concurrent checks; needs clk and rst_n in scope.
`ifndef KEYED_RECORD_TABLE_WITH_MEAN_MACROS_SVH
`define KEYED_RECORD_TABLE_WITH_MEAN_MACROS_SVH
`ifndef SYNTHESIS
`define KRT_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("keyed_record_table_with_mean: same-cycle check failed");
`define KRT_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("keyed_record_table_with_mean: next-cycle check failed");
`else
`define KRT_ASSERT_IMP(label, ante, cons)
`define KRT_ASSERT_NXT(label, ante, cons)
`endif
`endif

// ===== sv/krt_pkg.sv =====
// Shared types and constants for the keyed record table.
// No dependencies; imported by krt_store, the top level and both testbench modules.
package krt_pkg;

    localparam int WEIGHT_W = 12;
    localparam int RUN_W    = 6;

    localparam logic [1:0] MODE_UPSERT = 2'd0;
    localparam logic [1:0] MODE_LEN    = 2'd1;
    localparam logic [1:0] MODE_MEAN   = 2'd2;

    typedef enum logic [1:0] {
        ST_UPDATED  = 2'd0,
        ST_APPENDED = 2'd1,
        ST_FULL     = 2'd2,
        ST_ANSWERED = 2'd3
    } krt_status_t;

    typedef struct packed {
        logic [1:0]  mode;
        logic [7:0]  key;
        logic [11:0] live_value;
        logic [11:0] weight;
    } krt_cmd_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [5:0]  run_length;
        logic [11:0] mean_weight;
    } krt_res_t;

    // Record layout: key in bits 7:0, live value 19:8, weight 31:20.
    typedef struct packed {
        logic [11:0] weight;
        logic [11:0] live;
        logic [7:0]  key;
    } krt_rec_t;

    // Write command from the sequencer to the record store.
    typedef struct packed {
        logic wr;         // write wr_rec at wr_addr
        logic kill_next;  // mark the slot after wr_addr dead
    } krt_wcmd_t;

endpackage

// ===== sv/krt_store.sv =====
// Record store: one synchronous memory with a registered read port.
// Per-slot valid bits make never-written or killed slots read as zero. Uses krt_pkg.
module krt_store
    import krt_pkg::*;
#(
    parameter int SLOTS  = 41,
    parameter int ADDR_W = 6
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [ADDR_W-1:0] rd_addr,
    output krt_rec_t          rd_rec,
    input  krt_wcmd_t         wcmd,
    input  logic [ADDR_W-1:0] wr_addr,
    input  krt_rec_t          wr_rec
);

    krt_rec_t          mem [SLOTS];
    krt_rec_t          rd_data_reg;
    logic              rd_vld_reg;
    logic [SLOTS-1:0]  vld_reg;
    logic [SLOTS-1:0]  vld_next;
    logic [ADDR_W:0]   nxt_sum;
    logic              nxt_ok;
    logic [ADDR_W-1:0] nxt_addr;

    assign nxt_sum  = {1'b0, wr_addr} + (ADDR_W+1)'(1);
    assign nxt_ok   = nxt_sum < (ADDR_W+1)'(SLOTS);
    assign nxt_addr = nxt_sum[ADDR_W-1:0];

    always_comb
    begin
        vld_next = vld_reg;
        if (wcmd.wr)
        begin
            vld_next[wr_addr] = 1'b1;
        end
        // drop the following slot; its key and weight are never looked at again
        if (wcmd.kill_next && nxt_ok)
        begin
            vld_next[nxt_addr] = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
        if (wcmd.wr)
        begin
            mem[wr_addr] <= wr_rec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            rd_vld_reg <= vld_reg[rd_addr];
            vld_reg    <= vld_next;
        end
    end

    assign rd_rec = rd_vld_reg ? rd_data_reg : '0;

endmodule

// ===== sv/krt_div.sv =====
// Restoring divider, one quotient bit per cycle.
// Uses nothing from the package; instantiated by the top level for the mean.
module krt_div
#(
    parameter int NUM_W = 18,
    parameter int DEN_W = 6
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [NUM_W-1:0] quo
);

    localparam int CW = $clog2(NUM_W + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CW-1:0]    cnt_reg;
    logic [NUM_W-1:0] quo_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic [DEN_W:0]   rem_sh;
    logic [DEN_W:0]   rem_sub;
    logic             ge;

    always_comb
    begin
        rem_sh  = {rem_reg, quo_reg[NUM_W-1]};
        ge      = rem_sh >= {1'b0, den_reg};
        rem_sub = rem_sh - {1'b0, den_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            quo_reg  <= '0;
            rem_reg  <= '0;
            den_reg  <= '0;
        end
        else
        begin
            // pulse done on the last quotient bit
            done_reg <= !start && busy_reg && (cnt_reg == CW'(1));
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(NUM_W);
                quo_reg  <= num;
                rem_reg  <= '0;
                den_reg  <= den;
            end
            else if (busy_reg)
            begin
                quo_reg <= {quo_reg[NUM_W-2:0], ge};
                rem_reg <= ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

// ===== sv/keyed_record_table_with_mean.sv =====
// Keyed record table with run mean: TABLE_SLOTS records of key, live value and weight,
// held in one synchronous memory (krt_store) and walked from slot 0 one slot per cycle;
// the live run ends at the first record whose live value is zero. Mode 0 upserts a
// record (rewrite on key match, else append into the first dead slot and kill the slot
// after it; status 2 when the run fills the table), mode 1 answers the run length plus
// one, mode 2 the truncated mean of the run's weights (0 for an empty run), mode 3
// answers status 3 at once. All slots read as zero after reset; no clearing pass.
// One word is handled at a time: each upsert or query walks the slots from slot 0, one
// memory read per cycle, and a mean query of a non-empty run then runs the bit-serial
// divider. The next word is taken while the last result still waits in the output
// register. Depends on krt_pkg, krt_store, krt_div and the assertion macro header.
`include "keyed_record_table_with_mean_macros.svh"

module keyed_record_table_with_mean
    import krt_pkg::*;
#(
    parameter int TABLE_SLOTS = 41
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     cmd_valid,
    output logic     cmd_stall,
    input  krt_cmd_t cmd,
    output logic     res_valid,
    input  logic     res_stall,
    output krt_res_t res
);

    localparam int ADDR_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int CNT_W  = $clog2(TABLE_SLOTS + 1);
    localparam int SUM_W  = WEIGHT_W + CNT_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_DIV,
        S_FIN
    } state_t;

    state_t            state_reg;
    krt_cmd_t          cmd_reg;
    logic [ADDR_W-1:0] idx_reg;
    logic [SUM_W-1:0]  sum_reg;
    krt_res_t          pend_reg;
    logic              out_valid_reg;
    krt_res_t          out_reg;

    krt_rec_t          rd_rec;
    logic [ADDR_W-1:0] rd_addr;
    krt_wcmd_t         wcmd;
    krt_rec_t          wr_rec;

    logic              accept;
    logic              live;
    logic              hit;
    logic              last;
    logic              is_upsert;
    logic              walk_end;
    logic [CNT_W-1:0]  n_run;
    logic [SUM_W-1:0]  sum_fin;
    logic              div_start;
    logic              div_done;
    logic [SUM_W-1:0]  div_quo;
    logic              out_free;

    assign accept    = cmd_valid && !cmd_stall;
    assign cmd_stall = (state_reg != S_IDLE);
    assign out_free  = !out_valid_reg || !res_stall;

    // Slot idx_reg is under evaluation; its data was read in the previous cycle.
    always_comb
    begin
        live      = (rd_rec.live != '0);
        hit       = (rd_rec.key == cmd_reg.key);
        last      = (idx_reg == ADDR_W'(TABLE_SLOTS - 1));
        is_upsert = (cmd_reg.mode == MODE_UPSERT);
        // queries stop at the first dead slot or after the last slot
        walk_end  = (state_reg == S_WALK) && !is_upsert && (!live || last);
        n_run     = live ? CNT_W'(TABLE_SLOTS) : CNT_W'(idx_reg);
        sum_fin   = live ? (sum_reg + SUM_W'(rd_rec.weight)) : sum_reg;
        div_start = walk_end && (cmd_reg.mode == MODE_MEAN) && (n_run != '0);

        // prefetch the next slot so the walk advances one slot per cycle
        if (state_reg == S_WALK && !last)
        begin
            rd_addr = idx_reg + ADDR_W'(1);
        end
        else
        begin
            rd_addr = '0;
        end

        wcmd.wr        = (state_reg == S_WALK) && is_upsert && (!live || hit);
        wcmd.kill_next = (state_reg == S_WALK) && is_upsert && !live;
        wr_rec.key     = cmd_reg.key;
        wr_rec.live    = cmd_reg.live_value;
        wr_rec.weight  = cmd_reg.weight;
    end

    krt_store #(
        .SLOTS  (TABLE_SLOTS),
        .ADDR_W (ADDR_W)
    ) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_addr (rd_addr),
        .rd_rec  (rd_rec),
        .wcmd    (wcmd),
        .wr_addr (idx_reg),
        .wr_rec  (wr_rec)
    );

    krt_div #(
        .NUM_W (SUM_W),
        .DEN_W (CNT_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (sum_fin),
        .den   (n_run),
        .done  (div_done),
        .quo   (div_quo)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cmd_reg       <= '0;
            idx_reg       <= '0;
            sum_reg       <= '0;
            pend_reg      <= '0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            // retire the delivered word unless a new one is loaded in its place
            if (out_valid_reg && !res_stall && state_reg != S_FIN)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        cmd_reg  <= cmd;
                        idx_reg  <= '0;
                        sum_reg  <= '0;
                        case (cmd.mode)
                            MODE_UPSERT, MODE_LEN, MODE_MEAN:
                            begin
                                pend_reg  <= '0;
                                state_reg <= S_WALK;
                            end
                            default:
                            begin
                                // unused mode: answer status 3 with zero fields, touch nothing
                                pend_reg  <= '{status: ST_ANSWERED, run_length: '0,
                                               mean_weight: '0};
                                state_reg <= S_FIN;
                            end
                        endcase
                    end
                end

                S_WALK:
                begin
                    if (is_upsert)
                    begin
                        if (!live)
                        begin
                            pend_reg.status <= ST_APPENDED;
                            state_reg       <= S_FIN;
                        end
                        else if (hit)
                        begin
                            pend_reg.status <= ST_UPDATED;
                            state_reg       <= S_FIN;
                        end
                        else if (last)
                        begin
                            pend_reg.status <= ST_FULL;
                            state_reg       <= S_FIN;
                        end
                        else
                        begin
                            idx_reg <= idx_reg + ADDR_W'(1);
                        end
                    end
                    else if (walk_end)
                    begin
                        if (cmd_reg.mode == MODE_LEN)
                        begin
                            pend_reg  <= '{status: ST_ANSWERED,
                                           run_length: RUN_W'(n_run) + RUN_W'(1),
                                           mean_weight: '0};
                            state_reg <= S_FIN;
                        end
                        else
                        begin
                            pend_reg.status <= ST_ANSWERED;
                            if (div_start)
                            begin
                                state_reg <= S_DIV;
                            end
                            else
                            begin
                                // empty run: mean stays zero
                                state_reg <= S_FIN;
                            end
                        end
                    end
                    else
                    begin
                        sum_reg <= sum_fin;
                        idx_reg <= idx_reg + ADDR_W'(1);
                    end
                end

                S_DIV:
                begin
                    if (div_done)
                    begin
                        pend_reg.mean_weight <= div_quo[WEIGHT_W-1:0];
                        state_reg            <= S_FIN;
                    end
                end

                S_FIN:
                begin
                    // hold the result until the output register is free
                    if (out_free)
                    begin
                        out_reg       <= pend_reg;
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign res_valid = out_valid_reg;
    assign res       = out_reg;

    // a word taken in locks the input until its result is loaded into the output register
    `KRT_ASSERT_NXT(a_accept_locks, accept, cmd_stall)
    // the walk never evaluates a slot past the end of the table
    `KRT_ASSERT_IMP(a_walk_in_range, state_reg == S_WALK, idx_reg <= ADDR_W'(TABLE_SLOTS - 1))
    // the divider only finishes while the sequencer waits for it
    `KRT_ASSERT_IMP(a_div_owned, div_done, state_reg == S_DIV)

endmodule

// ===== tb/sv/krt_checker.sv =====
// Scoreboard for the keyed record table: watches both channels, keeps its own copy
// of the table and compares every result word with the predicted one.
// Depends on krt_pkg; instantiated by tb_top beside the block.
module krt_checker
    import krt_pkg::*;
#(
    parameter int TABLE_SLOTS = 41
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     cmd_valid,
    input  logic     cmd_stall,
    input  krt_cmd_t cmd,
    input  logic     res_valid,
    input  logic     res_stall,
    input  krt_res_t res,
    output int       fail_count,
    output int       pending,
    output int       n_updated,
    output int       n_appended,
    output int       n_full,
    output int       n_answered
);
    timeunit 1ns;
    timeprecision 1ps;

    krt_rec_t slots [TABLE_SLOTS];
    krt_res_t due_q [$];

    // Length of the live run from slot 0.
    function automatic int live_run();
        int n;
        n = 0;
        while (n < TABLE_SLOTS && slots[n].live != '0)
            n++;
        return n;
    endfunction

    // Apply one command word to the shadow table and return the result word it earns.
    function automatic krt_res_t apply_word(krt_cmd_t w);
        krt_res_t    r;
        int          i;
        int          n;
        logic        found;
        logic [31:0] sum;
        r = '0;
        r.status = ST_ANSWERED;
        case (w.mode)
            MODE_UPSERT:
            begin
                i = 0;
                found = 1'b0;
                while (i < TABLE_SLOTS && slots[i].live != '0 && !found)
                begin
                    if (slots[i].key == w.key)
                        found = 1'b1;
                    else
                        i++;
                end
                if (i >= TABLE_SLOTS)
                    r.status = ST_FULL;
                else
                begin
                    slots[i].key    = w.key;
                    slots[i].live   = w.live_value;
                    slots[i].weight = w.weight;
                    if (!found && i + 1 < TABLE_SLOTS)
                        slots[i + 1].live = '0;
                    r.status = found ? ST_UPDATED : ST_APPENDED;
                end
            end
            MODE_LEN:
                r.run_length = 6'(live_run() + 1);
            MODE_MEAN:
            begin
                n = live_run();
                sum = '0;
                for (i = 0; i < n; i++)
                    sum += 32'(slots[i].weight);
                if (n != 0)
                    r.mean_weight = 12'(sum / n);
            end
            default:
                ;
        endcase
        return r;
    endfunction

    task automatic report_miss(string what, int got, int want);
        $display("krt_checker: %s: got %0d, expected %0d (t=%0t)", what, got, want, $time);
        fail_count = fail_count + 1;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        krt_res_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < TABLE_SLOTS; i++)
                slots[i] = '0;
            due_q.delete();
            fail_count = 0;
            pending    = 0;
            n_updated  = 0;
            n_appended = 0;
            n_full     = 0;
            n_answered = 0;
        end
        else
        begin
            // Results first: a word taken at this edge cannot have its result out yet.
            if (res_valid && !res_stall)
            begin
                if (due_q.size() == 0)
                    report_miss("result word with nothing pending, status", res.status, -1);
                else
                begin
                    want = due_q.pop_front();
                    if (res.status !== want.status)
                        report_miss("status", res.status, want.status);
                    if (res.run_length !== want.run_length)
                        report_miss("run_length", res.run_length, want.run_length);
                    if (res.mean_weight !== want.mean_weight)
                        report_miss("mean_weight", res.mean_weight, want.mean_weight);
                    case (want.status)
                        ST_UPDATED:  n_updated++;
                        ST_APPENDED: n_appended++;
                        ST_FULL:     n_full++;
                        default:     n_answered++;
                    endcase
                end
            end
            if (cmd_valid && !cmd_stall)
                due_q.push_back(apply_word(cmd));
            pending = due_q.size();
        end
    end

endmodule

// ===== tb/sv/tb_top.sv =====
// Testbench top for keyed_record_table_with_mean: clock, reset, command stimulus,
// result-side stall pattern, watchdog and verdict.
// Depends on krt_pkg, the block itself and krt_checker.
module tb_top;
    import krt_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int         TABLE_SLOTS  = 41;
    localparam int         RANDOM_WORDS = 1950;
    // Long enough for a worst-case mean walk plus the longest stall and sender gap,
    // taken many times over.
    localparam int         QUIET_LIMIT  = 3000;
    // Mode code the block leaves unused; it only answers.
    localparam logic [1:0] MODE_SPARE   = 2'd3;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     cmd_valid = 1'b0;
    logic     cmd_stall;
    krt_cmd_t cmd = '0;
    logic     res_valid;
    logic     res_stall = 1'b0;
    krt_res_t res;

    int fail_count;
    int pending;
    int n_updated;
    int n_appended;
    int n_full;
    int n_answered;

    int words_sent = 0;
    int burst_left = 0;
    int quiet = 0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    keyed_record_table_with_mean #(.TABLE_SLOTS(TABLE_SLOTS)) dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

    krt_checker #(.TABLE_SLOTS(TABLE_SLOTS)) table_check
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd_stall  (cmd_stall),
        .cmd        (cmd),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .res        (res),
        .fail_count (fail_count),
        .pending    (pending),
        .n_updated  (n_updated),
        .n_appended (n_appended),
        .n_full     (n_full),
        .n_answered (n_answered)
    );

    // Offer one word and hold it until the block takes it. Words go out in bursts;
    // between bursts drop valid for a random gap, sometimes a long one, sometimes none.
    // Stall is sampled at the falling edge, where it is settled for the next rise.
    task automatic push_word(krt_cmd_t w);
        int   gap;
        logic took;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 4);
            if (gap != 0)
            begin
                cmd_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        cmd       <= w;
        cmd_valid <= 1'b1;
        took = 1'b0;
        while (!took)
        begin
            @(negedge clk);
            took = !cmd_stall;
            @(posedge clk);
        end
        words_sent++;
    endtask

    function automatic krt_cmd_t pack_word(logic [1:0] m, logic [7:0] k,
                                           logic [11:0] lv, logic [11:0] wt);
        krt_cmd_t w;
        w.mode       = m;
        w.key        = k;
        w.live_value = lv;
        w.weight     = wt;
        return w;
    endfunction

    // Receiver: a random stall style for each run of random length - no stall at all,
    // light random, heavy random, or a fixed periodic stall.
    int stall_left = 0;
    int stall_style = 0;
    int stall_tick = 0;

    always @(posedge clk)
    begin
        stall_tick <= stall_tick + 1;
        if (stall_left == 0)
        begin
            stall_style <= $urandom_range(0, 3);
            stall_left  <= $urandom_range(50, 400);
        end
        else
            stall_left <= stall_left - 1;
        case (stall_style)
            0:       res_stall <= 1'b0;
            1:       res_stall <= ($urandom_range(0, 3) == 0);
            2:       res_stall <= ($urandom_range(0, 9) < 7);
            default: res_stall <= ((stall_tick % 16) < 5);
        endcase
    end

    // Watchdog: count cycles in which neither channel moves a word.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall))
                quiet <= 0;
            else
            begin
                quiet <= quiet + 1;
                if (quiet >= QUIET_LIMIT)
                begin
                    $display("watchdog: no word moved for %0d cycles, %0d still pending",
                             QUIET_LIMIT, pending);
                    $display("keyed_record_table_with_mean: mismatch");
                    $finish;
                end
            end
        end
    end

    initial
    begin
        logic [7:0]  key_pool [64];
        int          pool_n;
        int          dead_pct;
        int          weight_style;
        int          seg_len;
        int          pick;
        logic [1:0]  m;
        logic [7:0]  k;
        logic [11:0] lv;
        logic [11:0] wt;
        int          random_sent;
        logic        first_seg;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty table queries, the spare mode, extreme fields, rewrite of a
        // matching key, dead upserts that cut the run, an append in front of a hidden record
        // with a reused key, and the mean of an empty and of an all-max run.
        push_word(pack_word(MODE_LEN,    8'h00, 12'h000, 12'h000));
        push_word(pack_word(MODE_MEAN,   8'h00, 12'h000, 12'h000));
        push_word(pack_word(MODE_SPARE,  8'hFF, 12'hFFF, 12'hFFF));
        push_word(pack_word(MODE_UPSERT, 8'hFF, 12'hFFF, 12'hFFF));
        push_word(pack_word(MODE_UPSERT, 8'h00, 12'h001, 12'h000));
        push_word(pack_word(MODE_UPSERT, 8'hFF, 12'h800, 12'h001));
        push_word(pack_word(MODE_LEN,    8'hFF, 12'hFFF, 12'hFFF));
        push_word(pack_word(MODE_MEAN,   8'hFF, 12'hFFF, 12'hFFF));
        push_word(pack_word(MODE_UPSERT, 8'h5A, 12'h0A5, 12'hFFF));
        push_word(pack_word(MODE_MEAN,   8'h00, 12'h000, 12'h000));
        push_word(pack_word(MODE_UPSERT, 8'h00, 12'h000, 12'h123));
        push_word(pack_word(MODE_LEN,    8'h00, 12'h000, 12'h000));
        push_word(pack_word(MODE_MEAN,   8'h00, 12'h000, 12'h000));
        push_word(pack_word(MODE_UPSERT, 8'h5A, 12'h777, 12'h444));
        push_word(pack_word(MODE_LEN,    8'h00, 12'h000, 12'h000));
        push_word(pack_word(MODE_UPSERT, 8'hFF, 12'h000, 12'hABC));
        push_word(pack_word(MODE_MEAN,   8'h00, 12'h000, 12'h000));
        push_word(pack_word(MODE_LEN,    8'h00, 12'h000, 12'h000));
        push_word(pack_word(MODE_UPSERT, 8'h33, 12'hFFF, 12'hFFF));
        push_word(pack_word(MODE_MEAN,   8'h00, 12'h000, 12'h000));
        push_word(pack_word(MODE_SPARE,  8'h00, 12'h000, 12'h000));

        // Random: segments with their own key pool, dead-upsert rate and weight style.
        // The first segment draws from a wide pool with no dead upserts so the table
        // fills, the last slot is taken and further appends are dropped.
        random_sent = 0;
        first_seg = 1'b1;
        while (random_sent < RANDOM_WORDS)
        begin
            case ($urandom_range(0, 3))
                0:       pool_n = 6;
                1:       pool_n = 41;
                default: pool_n = 64;
            endcase
            case ($urandom_range(0, 3))
                0, 1:    dead_pct = 0;
                2:       dead_pct = 3;
                default: dead_pct = 12;
            endcase
            weight_style = $urandom_range(0, 5);
            seg_len = $urandom_range(100, 200);
            if (first_seg)
            begin
                pool_n = 64;
                dead_pct = 0;
                weight_style = 5;
                seg_len = 250;
                first_seg = 1'b0;
            end
            for (int i = 0; i < 64; i++)
                key_pool[i] = 8'($urandom);

            for (int j = 0; j < seg_len && random_sent < RANDOM_WORDS; j++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 68)
                begin
                    m = MODE_UPSERT;
                    k = ($urandom_range(0, 99) < 85) ? key_pool[$urandom_range(0, pool_n - 1)]
                                                     : 8'($urandom);
                    pick = $urandom_range(0, 99);
                    if (pick < dead_pct)
                        lv = 12'h000;
                    else if (pick < dead_pct + 4)
                        lv = 12'h001;
                    else if (pick < dead_pct + 8)
                        lv = 12'hFFF;
                    else
                        lv = 12'($urandom_range(1, 4095));
                    case (weight_style)
                        0:       wt = 12'hFFF;
                        1:       wt = 12'h000;
                        default: wt = 12'($urandom);
                    endcase
                end
                else
                begin
                    if (pick < 80)
                        m = MODE_LEN;
                    else if (pick < 94)
                        m = MODE_MEAN;
                    else
                        m = MODE_SPARE;
                    k  = 8'($urandom);
                    lv = 12'($urandom);
                    wt = 12'($urandom);
                end
                push_word(pack_word(m, k, lv, wt));
                random_sent++;
            end
        end

        cmd_valid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        // Hold a little longer to catch any stray result word.
        repeat (80) @(posedge clk);

        $display("Run covered %0d command words: %0d rewrites, %0d appends, %0d dropped on a full table,",
                 words_sent, n_updated, n_appended, n_full);
        $display("and %0d query or spare-mode answers.", n_answered);
        if (fail_count == 0 && pending == 0)
            $display("keyed_record_table_with_mean: match");
        else
            $display("keyed_record_table_with_mean: mismatch");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/krt_pkg.sv
sv/krt_store.sv
sv/krt_div.sv
sv/keyed_record_table_with_mean.sv
tb/sv/krt_checker.sv
tb/sv/tb_top.sv
